// File: rtl/core/b85_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_pkg: shared types and the alphabet lookup of the base85 decoder
// Status codes, the group record handed from the fold stage to the byte
// output stage, and the character to digit mapping (RFC 1924 alphabet).
// ----------------------------------------------------------------------------
package b85_pkg;

    localparam int unsigned RADIX     = 85;
    localparam int unsigned GROUP_LEN = 5;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_LEN  = 2'd2
    } t_status;

    typedef struct packed {
        logic       ok;
        logic [6:0] value;
    } t_digit;

    // One closed group or one error, as passed to the byte output stage
    typedef struct packed {
        logic [31:0] acc_plus;  // folded accumulator plus one
        logic [19:0] pad_mult;  // 85 to the power of the missing digits
        logic [1:0]  last_idx;  // number of bytes minus one
        t_status     status;
        logic        eot;
    } t_group;

    function automatic t_digit digit_of(input logic [7:0] ch);
        t_digit d;
        d.ok    = 1'b1;
        d.value = 7'd0;
        if (ch >= 8'd48 && ch <= 8'd57) begin
            d.value = 7'(ch - 8'd48);
        end else if (ch >= 8'd65 && ch <= 8'd90) begin
            d.value = 7'(ch - 8'd55);
        end else if (ch >= 8'd97 && ch <= 8'd122) begin
            d.value = 7'(ch - 8'd61);
        end else begin
            unique case (ch)
                8'd33:   d.value = 7'd62;
                8'd35:   d.value = 7'd63;
                8'd36:   d.value = 7'd64;
                8'd37:   d.value = 7'd65;
                8'd38:   d.value = 7'd66;
                8'd40:   d.value = 7'd67;
                8'd41:   d.value = 7'd68;
                8'd42:   d.value = 7'd69;
                8'd43:   d.value = 7'd70;
                8'd45:   d.value = 7'd71;
                8'd59:   d.value = 7'd72;
                8'd60:   d.value = 7'd73;
                8'd61:   d.value = 7'd74;
                8'd62:   d.value = 7'd75;
                8'd63:   d.value = 7'd76;
                8'd64:   d.value = 7'd77;
                8'd94:   d.value = 7'd78;
                8'd95:   d.value = 7'd79;
                8'd96:   d.value = 7'd80;
                8'd123:  d.value = 7'd81;
                8'd124:  d.value = 7'd82;
                8'd125:  d.value = 7'd83;
                8'd126:  d.value = 7'd84;
                default: d.ok    = 1'b0;
            endcase
        end
        return d;
    endfunction

endpackage

// File: rtl/core/b85_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_if: stream channels of the base85 decoder
// Character channel in, byte channel out, valid/ready handshake on each.
// ----------------------------------------------------------------------------
interface b85_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_text;

    modport source (output valid, output symbol, output end_of_text, input ready);
    modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

interface b85_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       run_last;
    logic       message_end;
    logic [1:0] status;

    modport source (output valid, output data_byte, output run_last,
                    output message_end, output status, input ready);
    modport sink   (input valid, input data_byte, input run_last,
                    input message_end, input status, output ready);
endinterface

// File: rtl/core/base85_stream_decoder.sv
`timescale 1ns / 1ps
// A character's first result passes the character, group and byte output registers in turn.
// Throughput: one character per cycle while no group waits for the byte output register;
// a closing character's bytes (up to four) leave in turn from that single register.
// Reset: synchronous, active low; clears accumulator, group count and error flag
// and empties the character, group and byte registers.
// ----------------------------------------------------------------------------
// base85_stream_decoder: streaming base85 decoder (RFC 1924 alphabet)
// Character register and fold stage feed a padding multiply and a byte
// output register; errors are reported once per message.
// ----------------------------------------------------------------------------
module base85_stream_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    b85_in_if.sink    i_text,
    b85_out_if.source o_bytes
);

    b85_pkg::t_group grp;
    logic            grp_valid;
    logic            grp_ready;

    b85_fold u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text      (i_text),
        .o_grp       (grp),
        .o_grp_valid (grp_valid),
        .i_grp_ready (grp_ready)
    );

    b85_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (grp),
        .i_grp_valid (grp_valid),
        .o_grp_ready (grp_ready),
        .o_bytes     (o_bytes)
    );

endmodule

// File: rtl/core/b85_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_fold: character register, digit fold and group state
// Maps each character to its digit, folds it into the accumulator and
// closes a group on the fifth character or at message end, or reports an error.
// ----------------------------------------------------------------------------
module b85_fold (
    input  logic              i_clk,
    input  logic              i_rst_n,
    b85_in_if.sink            i_text,
    output b85_pkg::t_group   o_grp,
    output logic              o_grp_valid,
    input  logic              i_grp_ready
);

    logic            r_in_valid;
    logic [7:0]      r_sym;
    logic            r_eot;

    logic [31:0]     r_acc;
    logic [2:0]      r_count;
    logic            r_err;
    logic [31:0]     n_acc;
    logic [2:0]      n_count;
    logic            n_err;

    logic            r_grp_valid;
    b85_pkg::t_group r_grp;
    logic            n_grp_valid;
    b85_pkg::t_group n_grp;

    b85_pkg::t_digit dig;
    logic [31:0]     folded;
    logic [2:0]      cnt1;
    logic            grp_free;
    logic            in_ready;
    logic            step;

    function automatic logic [19:0] pad_power(input logic [2:0] n);
        logic [19:0] p;
        unique case (n)
            3'd4:    p = 20'd85;
            3'd3:    p = 20'd7225;
            3'd2:    p = 20'd614125;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

    assign grp_free     = !r_grp_valid || i_grp_ready;
    assign in_ready     = !r_in_valid || grp_free;
    assign step         = r_in_valid && grp_free;
    assign i_text.ready = in_ready;
    assign o_grp        = r_grp;
    assign o_grp_valid  = r_grp_valid;

    assign dig    = b85_pkg::digit_of(r_sym);
    assign folded = 32'(r_acc * 32'd85) + {25'd0, dig.value};
    assign cnt1   = r_count + 3'd1;

    always_comb begin
        n_acc       = r_acc;
        n_count     = r_count;
        n_err       = r_err;
        n_grp_valid = 1'b0;
        n_grp       = '0;
        n_grp.eot   = r_eot;
        priority if (r_err) begin
            // discard until message end
            if (r_eot) begin
                n_err = 1'b0;
            end
        end else if (r_eot && r_count == 3'd0) begin
            n_grp_valid  = 1'b1;
            n_grp.status = b85_pkg::ST_BAD_LEN;
        end else if (!dig.ok) begin
            n_grp_valid  = 1'b1;
            n_grp.status = b85_pkg::ST_BAD_CHAR;
            n_acc        = '0;
            n_count      = '0;
            n_err        = !r_eot;
        end else if (cnt1 < 3'(b85_pkg::GROUP_LEN) && !r_eot) begin
            n_acc   = folded;
            n_count = cnt1;
        end else begin
            n_grp_valid    = 1'b1;
            n_grp.status   = b85_pkg::ST_OK;
            n_grp.acc_plus = folded + 32'd1;
            n_grp.pad_mult = pad_power(cnt1);
            n_grp.last_idx = 2'(cnt1 - 3'd2);
            n_acc          = '0;
            n_count        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_grp_valid <= 1'b0;
            r_acc       <= '0;
            r_count     <= '0;
            r_err       <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_text.valid;
            end
            if (grp_free) begin
                r_grp_valid <= step && n_grp_valid;
            end
            if (step) begin
                r_acc   <= n_acc;
                r_count <= n_count;
                r_err   <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_text.valid) begin
            r_sym <= i_text.symbol;
            r_eot <= i_text.end_of_text;
        end
        if (grp_free) begin
            r_grp <= n_grp;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < 3'(b85_pkg::GROUP_LEN))
        else $error("group count out of range");

    a_hold_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp_valid && !i_grp_ready |=> r_grp_valid && $stable(r_grp))
        else $error("stalled group record changed");

    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_eot |=> r_count == 3'd0 && !r_err && r_acc == 32'd0)
        else $error("message end left state behind");

endmodule

// File: rtl/core/b85_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_emit: padding multiply and byte output register
// Completes a group with the pad digit in one multiply, then hands out its
// bytes most significant first, one request per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module b85_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b85_pkg::t_group   i_grp,
    input  logic              i_grp_valid,
    output logic              o_grp_ready,
    b85_out_if.source         o_bytes
);

    logic            r_valid;
    logic [31:0]     r_word;
    logic [1:0]      r_idx;
    logic [1:0]      r_cnt;
    b85_pkg::t_status r_status;
    logic            r_eot;

    logic [31:0]     product;
    logic [31:0]     word;
    logic            is_last;
    logic            load_ok;

    // padding with k digits of 84 equals (acc + 1) * 85^k - 1
    assign product = i_grp.acc_plus * {12'd0, i_grp.pad_mult};
    assign word    = product - 32'd1;

    assign is_last     = r_idx == r_cnt;
    assign load_ok     = !r_valid || (o_bytes.ready && is_last);
    assign o_grp_ready = load_ok;

    assign o_bytes.valid       = r_valid;
    assign o_bytes.data_byte   = r_word[{~r_idx, 3'b000} +: 8];
    assign o_bytes.run_last    = is_last;
    assign o_bytes.message_end = is_last && r_eot;
    assign o_bytes.status      = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load_ok) begin
                r_valid <= i_grp_valid;
                r_idx   <= '0;
            end else if (o_bytes.ready) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok && i_grp_valid) begin
            r_word   <= (i_grp.status == b85_pkg::ST_OK) ? word : 32'd0;
            r_cnt    <= i_grp.last_idx;
            r_status <= i_grp.status;
            r_eot    <= i_grp.eot;
        end
    end

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status != b85_pkg::ST_OK |-> is_last && r_idx == 2'd0)
        else $error("error result not a single request");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status != b85_pkg::ST_OK |-> o_bytes.data_byte == 8'd0)
        else $error("error result carries data");

    a_len_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status == b85_pkg::ST_BAD_LEN |-> r_eot)
        else $error("length error outside message end");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for base85_stream_decoder
// Sends character messages (directed corner cases, then random messages with
// some broken ones), predicts the decoded bytes and status results in the
// bench, and checks every result field against the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;

    localparam string B85_ALPHABET =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!#$%&()*+-;<=>?@^_`{|}~";
    localparam int unsigned PAD_DIGIT = b85_pkg::RADIX - 1;

    typedef struct {
        logic [7:0] symbol;
        logic       eot;
        bit         drain_first;
    } t_char_req;

    typedef struct {
        logic [7:0]       data_byte;
        logic             run_last;
        logic             message_end;
        b85_pkg::t_status status;
    } t_byte_res;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    b85_in_if  text_ch ();
    b85_out_if bytes_ch ();

    base85_stream_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_ch),
        .o_bytes (bytes_ch)
    );

    t_char_req   chars_to_send[$];
    t_byte_res   bytes_due[$];

    // decoder state as the bench sees it
    logic [31:0] fold_acc    = '0;
    int unsigned fold_count  = 0;
    bit          msg_dropped = 1'b0;

    int          chars_taken  = 0;
    int          fail_count   = 0;
    int          tx_gap       = 0;
    int          rx_gap       = 0;
    int          hold_cycles  = 0;
    bit          hold_done    = 1'b0;
    bit          calm_tail    = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL base85_stream_decoder");
        $finish;
    end

    function automatic int digit_value(input logic [7:0] ch);
        for (int i = 0; i < b85_pkg::RADIX; i++) begin
            if (B85_ALPHABET[i] == ch) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void clear_fold();
        fold_acc    = '0;
        fold_count  = 0;
        msg_dropped = 1'b0;
    endfunction

    // Append one expected result
    function automatic void add_due(input logic [7:0] b, input logic rl, input logic me,
                                    input b85_pkg::t_status st);
        t_byte_res r;
        r.data_byte   = b;
        r.run_last    = rl;
        r.message_end = me;
        r.status      = st;
        bytes_due     = {bytes_due, r};
    endfunction

    // Work out the results one accepted character causes
    function automatic void predict_bytes(input logic [7:0] ch, input logic eot);
        int          d;
        int unsigned nbytes;
        bit          tail;
        if (msg_dropped) begin
            if (eot) begin
                clear_fold();
            end
            return;
        end
        // length is checked before the character itself
        if (eot && fold_count == 0) begin
            add_due(8'd0, 1'b1, 1'b1, b85_pkg::ST_BAD_LEN);
            clear_fold();
            return;
        end
        d = digit_value(ch);
        if (d < 0) begin
            add_due(8'd0, 1'b1, eot, b85_pkg::ST_BAD_CHAR);
            clear_fold();
            msg_dropped = !eot;
            return;
        end
        fold_acc   = fold_acc * 32'(b85_pkg::RADIX) + 32'(d);
        fold_count = fold_count + 1;
        if (fold_count < b85_pkg::GROUP_LEN && !eot) begin
            return;
        end
        for (int j = fold_count; j < b85_pkg::GROUP_LEN; j++) begin
            fold_acc = fold_acc * 32'(b85_pkg::RADIX) + 32'(PAD_DIGIT);
        end
        nbytes = fold_count - 1;
        for (int j = 0; j < nbytes; j++) begin
            tail = (j + 1 == nbytes);
            add_due(fold_acc[31 - 8 * j -: 8], tail, tail && eot, b85_pkg::ST_OK);
        end
        clear_fold();
    endfunction

    task automatic queue_char(input logic [7:0] ch, input logic eot, input bit drain);
        t_char_req req;
        req.symbol      = ch;
        req.eot         = eot;
        req.drain_first = drain;
        chars_to_send   = {chars_to_send, req};
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            queue_char(s[i], i == s.len() - 1, 1'b0);
        end
    endtask

    // Random message: mostly well formed, some single leftovers, some bad characters
    task automatic queue_random_message(inout int counted, input bit drain);
        int         len;
        int         bad_at;
        logic [7:0] ch;
        len    = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 13);
        bad_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (i == bad_at) begin
                ch = 8'($urandom_range(0, 255));
                while (digit_value(ch) >= 0) begin
                    ch = 8'($urandom_range(0, 255));
                end
            end else if ($urandom_range(0, 7) == 0) begin
                ch = B85_ALPHABET[($urandom_range(0, 1) == 0) ? 0 : b85_pkg::RADIX - 1];
            end else begin
                ch = B85_ALPHABET[$urandom_range(0, b85_pkg::RADIX - 1)];
            end
            queue_char(ch, i == len - 1, drain && i == 0);
        end
        counted += len;
    endtask

    // Character driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            text_ch.valid       <= 1'b0;
            text_ch.symbol      <= 8'd0;
            text_ch.end_of_text <= 1'b0;
        end else begin
            if (text_ch.valid && text_ch.ready) begin
                predict_bytes(text_ch.symbol, text_ch.end_of_text);
                chars_taken <= chars_taken + 1;
            end
            calm_tail <= (chars_to_send.size() <= 25);
            if (!text_ch.valid || text_ch.ready) begin
                if (tx_gap > 0) begin
                    tx_gap = tx_gap - 1;
                    text_ch.valid <= 1'b0;
                end else if (chars_to_send.size() == 0) begin
                    text_ch.valid <= 1'b0;
                end else if (chars_to_send[0].drain_first && bytes_due.size() != 0) begin
                    // hold the next request until every pending byte is out
                    text_ch.valid <= 1'b0;
                end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                    tx_gap = $urandom_range(0, 4);
                    text_ch.valid <= 1'b0;
                end else begin
                    text_ch.valid       <= 1'b1;
                    text_ch.symbol      <= chars_to_send[0].symbol;
                    text_ch.end_of_text <= chars_to_send[0].eot;
                    void'(chars_to_send.pop_front());
                end
            end
        end
    end

    // Long receiver hold-off once the run is well under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end else if (!hold_done && chars_taken >= 60) begin
            hold_cycles <= 300;
            hold_done   <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Byte monitor and checker
    always @(posedge i_clk) begin
        t_byte_res want;
        t_byte_res got;
        if (!i_rst_n) begin
            bytes_ch.ready <= 1'b0;
        end else begin
            if (bytes_ch.valid && bytes_ch.ready) begin
                got.data_byte   = bytes_ch.data_byte;
                got.run_last    = bytes_ch.run_last;
                got.message_end = bytes_ch.message_end;
                got.status      = b85_pkg::t_status'(bytes_ch.status);
                if (bytes_due.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected result byte=%02h last=%b end=%b status=%0d",
                                 $realtime, got.data_byte, got.run_last, got.message_end,
                                 got.status);
                    end
                end else begin
                    want = bytes_due.pop_front();
                    if (got.data_byte !== want.data_byte || got.run_last !== want.run_last ||
                        got.message_end !== want.message_end || got.status !== want.status)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch expected byte=%02h last=%b end=%b status=%0d",
                                     $realtime, want.data_byte, want.run_last,
                                     want.message_end, want.status);
                            $display("%0t:          actual   byte=%02h last=%b end=%b status=%0d",
                                     $realtime, got.data_byte, got.run_last,
                                     got.message_end, got.status);
                        end
                    end
                end
            end
            if (hold_cycles != 0) begin
                bytes_ch.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap = rx_gap - 1;
                bytes_ch.ready <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(0, 4);
                bytes_ch.ready <= 1'b0;
            end else begin
                bytes_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int counted;
        bit drained;
        bit drain_now;
        text_ch.valid       = 1'b0;
        text_ch.symbol      = 8'd0;
        text_ch.end_of_text = 1'b0;
        bytes_ch.ready      = 1'b0;

        // single leftover character
        queue_text("0");
        // full group of top digits (wraps), then a two character tail
        queue_text("~~~~~~~");
        queue_text("zzz");
        queue_text("ABCD");
        // bad character mid message, rest dropped including the closing one
        queue_char("a", 1'b0, 1'b0);
        queue_char("b", 1'b0, 1'b0);
        queue_char(8'hFF, 1'b0, 1'b0);
        queue_char("c", 1'b0, 1'b0);
        queue_char("d", 1'b1, 1'b0);
        // bad character that closes the message
        queue_char("x", 1'b0, 1'b0);
        queue_char(8'h00, 1'b1, 1'b0);
        // unknown character alone: length is reported, not the character
        queue_char(8'h80, 1'b1, 1'b0);

        counted = 0;
        drained = 1'b0;
        while (counted < 95) begin
            // one message waits until every earlier result is out
            drain_now = !drained && counted >= 50;
            queue_random_message(counted, drain_now);
            drained = drained || drain_now;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (chars_to_send.size() != 0 || text_ch.valid) begin
            @(posedge i_clk);
        end
        while (bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && bytes_due.size() == 0) begin
            $display("PASS base85_stream_decoder");
        end else begin
            $display("FAIL base85_stream_decoder");
        end
        $finish;
    end

endmodule
